// File: rtl/iopdt_pkg.sv
// ----------------------------------------------------------------------------
// I/O port dispatch table package
// Shared widths, codes, entry layout and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package iopdt_pkg;

  // Default table depth for the top level.
  localparam int TABLE_DEPTH = 64;

  // Field widths.
  localparam int PORT_W  = 16;
  localparam int FLAG_W  = 2;
  localparam int TAG_W   = 16;
  localparam int BYTES_W = 3;
  localparam int DATA_W  = 32;
  localparam int LIMIT_W = 7;
  localparam int USED_W  = 7;

  // Entry limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Flag bit positions inside an entry.
  localparam int FLAG_FIXED_BIT = 0;
  localparam int FLAG_DRV_BIT   = 1;

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_DETACH = 2'd1,
    OP_ACCESS = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_NO_SPACE   = 3'd1,
    STATUS_EXISTS     = 3'd2,
    STATUS_NO_PERM    = 3'd3,
    STATUS_NOT_FOUND  = 3'd4,
    STATUS_NO_HANDLER = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SHIFT,
    ST_COMMIT,
    ST_RESULT
  } ctrl_state_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [FLAG_W-1:0] flags;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // One request item.
  typedef struct packed {
    logic [1:0]         operation;
    logic [PORT_W-1:0]  port;
    logic [FLAG_W-1:0]  entry_flags;
    logic [TAG_W-1:0]   handler_tag;
    logic               by_driver;
    logic               is_read;
    logic [BYTES_W-1:0] access_bytes;
    logic [DATA_W-1:0]  access_data;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   found_tag;
    logic               fwd_is_read;
    logic [BYTES_W-1:0] fwd_bytes;
    logic [DATA_W-1:0]  fwd_data;
    logic [USED_W-1:0]  entries_used;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_run;
    logic    shift_up_start;
    logic    shift_dn_start;
    logic    shift_run;
    logic    commit_ins;
    logic    commit_del;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              scan_done;
    logic              hit_eq;
    logic [FLAG_W-1:0] hit_flags;
    logic              shift_done;
    logic              full;
    logic [1:0]        operation;
    logic              by_driver;
    logic              out_free;
  } sts_t;

endpackage

// File: rtl/iopdt_if.sv
// ----------------------------------------------------------------------------
// I/O port dispatch table channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel.
interface iopdt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [iopdt_pkg::PORT_W-1:0]   port;
  logic [iopdt_pkg::FLAG_W-1:0]   entry_flags;
  logic [iopdt_pkg::TAG_W-1:0]    handler_tag;
  logic                           by_driver;
  logic                           is_read;
  logic [iopdt_pkg::BYTES_W-1:0]  access_bytes;
  logic [iopdt_pkg::DATA_W-1:0]   access_data;

  modport source (
    output valid, operation, port, entry_flags, handler_tag, by_driver, is_read,
           access_bytes, access_data,
    input  ready
  );
  modport sink (
    input  valid, operation, port, entry_flags, handler_tag, by_driver, is_read,
           access_bytes, access_data,
    output ready
  );
endinterface

// Result channel.
interface iopdt_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [iopdt_pkg::TAG_W-1:0]    found_tag;
  logic                           fwd_is_read;
  logic [iopdt_pkg::BYTES_W-1:0]  fwd_bytes;
  logic [iopdt_pkg::DATA_W-1:0]   fwd_data;
  logic [iopdt_pkg::USED_W-1:0]   entries_used;

  modport source (
    output valid, status, found_tag, fwd_is_read, fwd_bytes, fwd_data, entries_used,
    input  ready
  );
  modport sink (
    input  valid, status, found_tag, fwd_is_read, fwd_bytes, fwd_data, entries_used,
    output ready
  );
endinterface

// Configuration write channel for the entry limit register.
interface iopdt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iopdt_pkg::LIMIT_W-1:0]  entry_limit;

  modport source (output valid, entry_limit, input ready);
  modport sink   (input valid, entry_limit, output ready);
endinterface

// File: rtl/iopdt_ctrl.sv
// ----------------------------------------------------------------------------
// I/O port dispatch table controller
// Sequences each item through check, table scan, entry shift, commit and
// result hand-off, and picks the status code.
// ----------------------------------------------------------------------------
module iopdt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  iopdt_pkg::sts_t sts,
  output iopdt_pkg::cmd_t cmd
);

  iopdt_pkg::ctrl_state_t state_r, state_nxt;
  iopdt_pkg::status_t     status_r, status_nxt;
  logic                   drv_flag;

  assign drv_flag = sts.hit_flags[iopdt_pkg::FLAG_DRV_BIT];

  // State and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= iopdt_pkg::ST_IDLE;
      status_r <= iopdt_pkg::STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = status_r;
    case (state_r)
      iopdt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = iopdt_pkg::ST_CHECK;
        end
      end
      iopdt_pkg::ST_CHECK: begin
        status_nxt = iopdt_pkg::STATUS_OK;
        case (sts.operation)
          iopdt_pkg::OP_ATTACH: begin
            if (sts.full) begin
              status_nxt = iopdt_pkg::STATUS_NO_SPACE;
              state_nxt  = iopdt_pkg::ST_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = iopdt_pkg::ST_SCAN;
            end
          end
          iopdt_pkg::OP_DETACH, iopdt_pkg::OP_ACCESS: begin
            cmd.scan_start = 1'b1;
            state_nxt      = iopdt_pkg::ST_SCAN;
          end
          default: begin
            state_nxt = iopdt_pkg::ST_RESULT;
          end
        endcase
      end
      iopdt_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = iopdt_pkg::ST_RESULT;
          case (sts.operation)
            iopdt_pkg::OP_ATTACH: begin
              if (sts.hit_eq) begin
                status_nxt = iopdt_pkg::STATUS_EXISTS;
              end else begin
                cmd.shift_up_start = 1'b1;
                state_nxt          = iopdt_pkg::ST_SHIFT;
              end
            end
            iopdt_pkg::OP_DETACH: begin
              if (!sts.hit_eq) begin
                status_nxt = iopdt_pkg::STATUS_NOT_FOUND;
              end else if (sts.hit_flags[iopdt_pkg::FLAG_FIXED_BIT] ||
                           (drv_flag != sts.by_driver)) begin
                status_nxt = iopdt_pkg::STATUS_NO_PERM;
              end else begin
                cmd.shift_dn_start = 1'b1;
                state_nxt          = iopdt_pkg::ST_SHIFT;
              end
            end
            iopdt_pkg::OP_ACCESS: begin
              if (!sts.hit_eq) begin
                status_nxt = iopdt_pkg::STATUS_NO_HANDLER;
              end
            end
            default: begin
              status_nxt = iopdt_pkg::STATUS_OK;
            end
          endcase
        end
      end
      iopdt_pkg::ST_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (sts.shift_done) begin
          state_nxt = iopdt_pkg::ST_COMMIT;
        end
      end
      iopdt_pkg::ST_COMMIT: begin
        if (sts.operation == iopdt_pkg::OP_ATTACH) begin
          cmd.commit_ins = 1'b1;
        end else begin
          cmd.commit_del = 1'b1;
        end
        state_nxt = iopdt_pkg::ST_RESULT;
      end
      iopdt_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = iopdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iopdt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/iopdt_dp.sv
// ----------------------------------------------------------------------------
// I/O port dispatch table datapath
// Holds the sorted entry memory, the entry count and limit, the streaming
// scan and shift engine, and the result register.
// ----------------------------------------------------------------------------
module iopdt_dp #(
  parameter int TABLE_DEPTH = iopdt_pkg::TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iopdt_pkg::item_t                   item,
  input  logic                               cfg_we,
  input  logic [iopdt_pkg::LIMIT_W-1:0]      cfg_limit,
  input  logic                               out_ready,
  output logic                               out_valid,
  output iopdt_pkg::result_t                 result,
  input  iopdt_pkg::cmd_t                    cmd,
  output iopdt_pkg::sts_t                    sts
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > iopdt_pkg::LIMIT_W) ? CW : iopdt_pkg::LIMIT_W;

  // Entry memory and its registered read port.
  iopdt_pkg::entry_t mem [TABLE_DEPTH];
  iopdt_pkg::entry_t rdata_r;

  // Control registers.
  logic [CW-1:0]                 count_r;
  logic [iopdt_pkg::LIMIT_W-1:0] limit_r;
  logic                          out_valid_r;
  logic                          p_vld_r;
  logic                          shift_up_r;

  // Payload registers.
  iopdt_pkg::item_t   item_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      p_idx_r;
  logic [CW-1:0]      pos_r;
  iopdt_pkg::entry_t  hit_r;
  iopdt_pkg::result_t result_r;

  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  iopdt_pkg::entry_t wdata;
  iopdt_pkg::entry_t new_entry;
  logic              scan_issue;
  logic              scan_hit;
  logic              scan_done;
  logic [CW-1:0]     scan_pos;
  logic              shift_go;
  logic [CW-1:0]     shift_dst;
  logic [EW-1:0]     limit_ext;
  logic [EW-1:0]     depth_ext;
  logic [EW-1:0]     eff_limit;
  logic              is_ok;
  logic              tag_out;
  logic              fwd_out;

  // Read address: an upward shift reads the entry below the destination.
  assign rd_idx = shift_up_r ? (idx_r - 1'b1) : idx_r;
  assign raddr  = rd_idx[AW-1:0];

  // Scan finds the first entry whose port is not below the key.
  assign scan_issue = (idx_r < count_r);
  assign scan_hit   = p_vld_r && (rdata_r.port >= item_r.port);
  assign scan_done  = scan_hit || (!p_vld_r && !scan_issue);
  assign scan_pos   = scan_hit ? p_idx_r : count_r;

  // Shift moves entries one place up (insert) or down (remove).
  assign shift_go  = shift_up_r ? (idx_r > pos_r) : (idx_r < count_r);
  assign shift_dst = shift_up_r ? idx_r : (idx_r - 1'b1);

  // Memory write port: shifted entries, or the new entry on insert.
  assign new_entry = '{port: item_r.port, flags: item_r.entry_flags, tag: item_r.handler_tag};
  assign mem_we    = (cmd.shift_run && p_vld_r) || cmd.commit_ins;
  assign waddr     = cmd.commit_ins ? pos_r[AW-1:0] : p_idx_r[AW-1:0];
  assign wdata     = cmd.commit_ins ? new_entry : rdata_r;

  // Effective limit is the smaller of the register and the depth.
  assign limit_ext = EW'(limit_r);
  assign depth_ext = EW'(TABLE_DEPTH);
  assign eff_limit = (limit_ext < depth_ext) ? limit_ext : depth_ext;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      limit_r     <= iopdt_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      shift_up_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      if (cmd.commit_ins) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.commit_del) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.scan_start) begin
        shift_up_r <= 1'b0;
      end else if (cmd.shift_up_start) begin
        shift_up_r <= 1'b1;
      end else if (cmd.shift_dn_start) begin
        shift_up_r <= 1'b0;
      end
      if (cmd.scan_start || cmd.shift_up_start || cmd.shift_dn_start) begin
        p_vld_r <= 1'b0;
      end else if (cmd.scan_run) begin
        p_vld_r <= scan_issue;
      end else if (cmd.shift_run) begin
        p_vld_r <= shift_go;
      end
    end
  end

  // Item, scan index and match registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.shift_up_start) begin
      idx_r <= count_r;
    end else if (cmd.shift_dn_start) begin
      idx_r <= scan_pos + 1'b1;
    end else if (cmd.scan_run && scan_issue) begin
      idx_r   <= idx_r + 1'b1;
      p_idx_r <= idx_r;
    end else if (cmd.shift_run && shift_go) begin
      idx_r   <= shift_up_r ? (idx_r - 1'b1) : (idx_r + 1'b1);
      p_idx_r <= shift_dst;
    end
    if (cmd.scan_run && scan_done) begin
      pos_r <= scan_pos;
      hit_r <= rdata_r;
    end
  end

  // Result register.
  assign is_ok   = (cmd.res_status == iopdt_pkg::STATUS_OK);
  assign tag_out = is_ok && ((item_r.operation == iopdt_pkg::OP_DETACH) ||
                             (item_r.operation == iopdt_pkg::OP_ACCESS));
  assign fwd_out = is_ok && (item_r.operation == iopdt_pkg::OP_ACCESS);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result_r.status       <= cmd.res_status;
      result_r.found_tag    <= tag_out ? hit_r.tag : '0;
      result_r.fwd_is_read  <= fwd_out ? item_r.is_read : 1'b0;
      result_r.fwd_bytes    <= fwd_out ? item_r.access_bytes : '0;
      result_r.fwd_data     <= (fwd_out && !item_r.is_read) ? item_r.access_data : '0;
      result_r.entries_used <= iopdt_pkg::USED_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Status toward the controller.
  assign sts.scan_done  = scan_done;
  assign sts.hit_eq     = scan_hit && (rdata_r.port == item_r.port);
  assign sts.hit_flags  = rdata_r.flags;
  assign sts.shift_done = !shift_go && !p_vld_r;
  assign sts.full       = (EW'(count_r) >= eff_limit);
  assign sts.operation  = item_r.operation;
  assign sts.by_driver  = item_r.by_driver;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// File: rtl/io_port_dispatch_table_unit.sv
// Flow: a taken item is checked; an attach to a full table or the unused code goes straight to
// the result. Otherwise the table is scanned; an access, or an attach or detach refused after
// the scan, then loads its result, while an accepted attach or detach shifts entries, commits
// and then loads its result. Throughput: one item at a time, with a one-entry-per-cycle scan
// and shift; a stalled result holds off the input.
// Reset: synchronous; the table is empty, the limit is 64, no result pending.
// ----------------------------------------------------------------------------
// I/O port dispatch table top level
// Sorted table of I/O port entries with attach, detach and access lookup.
// ----------------------------------------------------------------------------
module io_port_dispatch_table_unit #(
  parameter int TABLE_DEPTH = iopdt_pkg::TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  iopdt_in_if.sink   in_chan,
  iopdt_out_if.source out_chan,
  iopdt_cfg_if.sink  cfg_chan
);

  iopdt_pkg::item_t   item;
  iopdt_pkg::result_t result;
  iopdt_pkg::cmd_t    cmd;
  iopdt_pkg::sts_t    sts;
  logic               in_ready;
  logic               out_valid;

  // Pack the request fields.
  assign item.operation    = in_chan.operation;
  assign item.port         = in_chan.port;
  assign item.entry_flags  = in_chan.entry_flags;
  assign item.handler_tag  = in_chan.handler_tag;
  assign item.by_driver    = in_chan.by_driver;
  assign item.is_read      = in_chan.is_read;
  assign item.access_bytes = in_chan.access_bytes;
  assign item.access_data  = in_chan.access_data;
  assign in_chan.ready     = in_ready;

  // The limit register takes a write in any cycle.
  assign cfg_chan.ready = 1'b1;

  // Unpack the result fields.
  assign out_chan.valid        = out_valid;
  assign out_chan.status       = result.status;
  assign out_chan.found_tag    = result.found_tag;
  assign out_chan.fwd_is_read  = result.fwd_is_read;
  assign out_chan.fwd_bytes    = result.fwd_bytes;
  assign out_chan.fwd_data     = result.fwd_data;
  assign out_chan.entries_used = result.entries_used;

  iopdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iopdt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cfg_we    (cfg_chan.valid),
    .cfg_limit (cfg_chan.entry_limit),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: verif/tb_io_port_dispatch_table_unit.sv
// ----------------------------------------------------------------------------
// I/O port dispatch table unit testbench
// Sends attach, detach and access requests, predicts each response from a
// shadow copy of the sorted port table, and checks every response field by
// field. The run covers several entry limits and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_io_port_dispatch_table_unit;
  import iopdt_pkg::*;

  localparam int         CLK_HALF      = 6;
  localparam int         RESET_CYCLES  = 6;
  localparam int         POOL_SIZE     = 72;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int         MAX_REPORTS   = 10;
  localparam longint     RUN_LIMIT     = 64'd12 * 64'd1_500_000;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  iopdt_in_if  req_bus ();
  iopdt_out_if rsp_bus ();
  iopdt_cfg_if cfg_bus ();

  io_port_dispatch_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (rsp_bus),
    .cfg_chan (cfg_bus)
  );

  // Shadow copy of the port table and the limit register.
  logic [PORT_W-1:0] shadow_port  [TABLE_DEPTH];
  logic [FLAG_W-1:0] shadow_flags [TABLE_DEPTH];
  logic [TAG_W-1:0]  shadow_tag   [TABLE_DEPTH];
  int                shadow_count = 0;
  int                shadow_limit = int'(LIMIT_RESET);

  // Request and response bookkeeping.
  item_t             pending_requests [$];
  result_t           expected_results [$];
  logic [PORT_W-1:0] port_pool [POOL_SIZE];
  item_t             drive_req;
  item_t             seen_req;
  result_t           seen_rsp;
  result_t           want_rsp;
  logic              req_taken = 1'b0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_kick = 1'b0;
  int                hold_left = 0;
  int                requests_accepted = 0;
  int                results_checked = 0;
  int                mismatches = 0;
  int                peak_entries = 0;
  int                status_seen [6] = '{default: 0};

  always #CLK_HALF clk = ~clk;

  // Returns the table index that holds the port, or the entry count on a miss.
  function automatic int find_port(input logic [PORT_W-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_port[i] == key) return i;
    end
    return shadow_count;
  endfunction

  // Applies one request to the shadow table and returns the response it gives.
  function automatic result_t dispatch_outcome(input item_t req);
    result_t rsp;
    int      idx;
    int      pos;
    int      cap;
    rsp = '0;
    rsp.status = STATUS_OK;
    idx = find_port(req.port);
    case (req.operation)
      OP_ATTACH: begin
        cap = (shadow_limit < TABLE_DEPTH) ? shadow_limit : TABLE_DEPTH;
        if (shadow_count >= cap) begin
          rsp.status = STATUS_NO_SPACE;
        end else if (idx < shadow_count) begin
          rsp.status = STATUS_EXISTS;
        end else begin
          pos = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_port[i] < req.port) pos = i + 1;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_port[i]  = shadow_port[i-1];
            shadow_flags[i] = shadow_flags[i-1];
            shadow_tag[i]   = shadow_tag[i-1];
          end
          shadow_port[pos]  = req.port;
          shadow_flags[pos] = req.entry_flags;
          shadow_tag[pos]   = req.handler_tag;
          shadow_count++;
        end
      end
      OP_DETACH: begin
        if (idx >= shadow_count) begin
          rsp.status = STATUS_NOT_FOUND;
        end else if (shadow_flags[idx][FLAG_FIXED_BIT]) begin
          rsp.status = STATUS_NO_PERM;
        end else if (shadow_flags[idx][FLAG_DRV_BIT] != req.by_driver) begin
          rsp.status = STATUS_NO_PERM;
        end else begin
          rsp.found_tag = shadow_tag[idx];
          for (int i = idx; i + 1 < shadow_count; i++) begin
            shadow_port[i]  = shadow_port[i+1];
            shadow_flags[i] = shadow_flags[i+1];
            shadow_tag[i]   = shadow_tag[i+1];
          end
          shadow_count--;
        end
      end
      OP_ACCESS: begin
        if (idx >= shadow_count) begin
          rsp.status = STATUS_NO_HANDLER;
        end else begin
          rsp.found_tag   = shadow_tag[idx];
          rsp.fwd_is_read = req.is_read;
          rsp.fwd_bytes   = req.access_bytes;
          rsp.fwd_data    = req.is_read ? '0 : req.access_data;
        end
      end
      OP_UNUSED: begin
        // The spare operation code leaves the table alone and answers OK.
        rsp.status = STATUS_OK;
      end
    endcase
    rsp.entries_used = USED_W'(shadow_count);
    return rsp;
  endfunction

  function automatic item_t make_req(input logic [1:0] op, input logic [PORT_W-1:0] key,
                                     input logic [FLAG_W-1:0] flags,
                                     input logic [TAG_W-1:0] tag, input logic drv,
                                     input logic rd, input logic [BYTES_W-1:0] bytes,
                                     input logic [DATA_W-1:0] data);
    item_t req;
    req.operation    = op;
    req.port         = key;
    req.entry_flags  = flags;
    req.handler_tag  = tag;
    req.by_driver    = drv;
    req.is_read      = rd;
    req.access_bytes = bytes;
    req.access_data  = data;
    return req;
  endfunction

  // Random request: ports mostly come from a shared pool so that attach,
  // detach and access meet each other, and the hook flag and the detach
  // party usually follow the low port bit so that most detaches are allowed.
  function automatic item_t random_request();
    item_t req;
    int    pick;
    pick = $urandom_range(0, 99);
    req.operation = (pick < 45) ? OP_ATTACH : (pick < 70) ? OP_DETACH :
                    (pick < 97) ? OP_ACCESS : OP_UNUSED;
    req.port = ($urandom_range(0, 99) < 85) ? port_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : PORT_W'($urandom);
    req.entry_flags[FLAG_FIXED_BIT] = ($urandom_range(0, 31) == 0);
    req.entry_flags[FLAG_DRV_BIT]   = ($urandom_range(0, 9) == 0) ? 1'($urandom)
                                                                  : req.port[0];
    req.handler_tag = TAG_W'($urandom);
    req.by_driver   = ($urandom_range(0, 9) == 0) ? 1'($urandom) : req.port[0];
    req.is_read     = 1'($urandom);
    pick = $urandom_range(0, 9);
    req.access_bytes = (pick == 0) ? BYTES_W'($urandom_range(0, 7)) :
                       (pick < 4) ? BYTES_W'(1) : (pick < 7) ? BYTES_W'(2) : BYTES_W'(4);
    req.access_data = DATA_W'($urandom);
    return req;
  endfunction

  // Request driver: offers the next queued item once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!req_bus.valid || req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_req = pending_requests.pop_front();
        req_bus.operation    <= drive_req.operation;
        req_bus.port         <= drive_req.port;
        req_bus.entry_flags  <= drive_req.entry_flags;
        req_bus.handler_tag  <= drive_req.handler_tag;
        req_bus.by_driver    <= drive_req.by_driver;
        req_bus.is_read      <= drive_req.is_read;
        req_bus.access_bytes <= drive_req.access_bytes;
        req_bus.access_data  <= drive_req.access_data;
        req_bus.valid        <= 1'b1;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls, plus a long hold-off when one is running.
  always @(negedge clk) begin
    rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  // Hold-off counter for the back-pressure phase.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: predicts each accepted request and checks each accepted response.
  always @(posedge clk) begin
    req_taken <= rst_n && req_bus.valid && req_bus.ready;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      seen_req = make_req(req_bus.operation, req_bus.port, req_bus.entry_flags,
                          req_bus.handler_tag, req_bus.by_driver, req_bus.is_read,
                          req_bus.access_bytes, req_bus.access_data);
      expected_results.push_back(dispatch_outcome(seen_req));
      requests_accepted++;
      if (shadow_count > peak_entries) peak_entries = shadow_count;
    end
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      seen_rsp.status       = status_t'(rsp_bus.status);
      seen_rsp.found_tag    = rsp_bus.found_tag;
      seen_rsp.fwd_is_read  = rsp_bus.fwd_is_read;
      seen_rsp.fwd_bytes    = rsp_bus.fwd_bytes;
      seen_rsp.fwd_data     = rsp_bus.fwd_data;
      seen_rsp.entries_used = rsp_bus.entries_used;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected response with no request outstanding: status %0d tag %h",
                   seen_rsp.status, seen_rsp.found_tag);
      end else begin
        want_rsp = expected_results.pop_front();
        results_checked++;
        status_seen[int'(want_rsp.status)]++;
        if (seen_rsp.status !== want_rsp.status ||
            seen_rsp.found_tag !== want_rsp.found_tag ||
            seen_rsp.fwd_is_read !== want_rsp.fwd_is_read ||
            seen_rsp.fwd_bytes !== want_rsp.fwd_bytes ||
            seen_rsp.fwd_data !== want_rsp.fwd_data ||
            seen_rsp.entries_used !== want_rsp.entries_used) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Response %0d mismatch: expected status %0d tag %h rd %b bytes %0d",
                     results_checked, want_rsp.status, want_rsp.found_tag,
                     want_rsp.fwd_is_read, want_rsp.fwd_bytes);
            $display("  expected data %h used %0d", want_rsp.fwd_data,
                     want_rsp.entries_used);
            $display("  got status %0d tag %h rd %b bytes %0d data %h used %0d",
                     seen_rsp.status, seen_rsp.found_tag, seen_rsp.fwd_is_read,
                     seen_rsp.fwd_bytes, seen_rsp.fwd_data, seen_rsp.entries_used);
          end
        end
      end
    end
  end

  // Writes the entry limit; only called while no request is in flight.
  task automatic set_entry_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid       = 1'b1;
    cfg_bus.entry_limit = value;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow_limit = int'(value);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Waits until every queued item has been sent and answered.
  task automatic wait_for_drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int idle_pct,
                           input int stall, input int count);
    set_entry_limit(limit);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) pending_requests.push_back(random_request());
    wait_for_drain();
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n                = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.operation    = OP_ATTACH;
    req_bus.port         = '0;
    req_bus.entry_flags  = '0;
    req_bus.handler_tag  = '0;
    req_bus.by_driver    = 1'b0;
    req_bus.is_read      = 1'b0;
    req_bus.access_bytes = '0;
    req_bus.access_data  = '0;
    rsp_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.entry_limit  = '0;

    port_pool[0] = '0;
    port_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = PORT_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty table, last-entry removal, duplicates, refusals
    // for fixed and hook-mismatched entries, odd sizes and the spare code.
    pending_requests.push_back(make_req(OP_ACCESS, 16'h0000, 2'd0, 16'h0, 1'b0, 1'b1,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h0000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h00ff, 2'd0, 16'h00aa, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h00ff, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ATTACH, 16'hffff, 2'd0, 16'hffff, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h0000, 2'd2, 16'h0000, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h8000, 2'd1, 16'h1234, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h8000, 2'd0, 16'h0001, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ACCESS, 16'hffff, 2'd3, 16'hffff, 1'b1, 1'b1,
                                        3'd4, 32'hffff_ffff));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h0000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'hffff_ffff));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h8000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd2, 32'ha5a5_5a5a));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h8000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd7, 32'h5a5a_a5a5));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h8000, 2'd0, 16'h0, 1'b0, 1'b1,
                                        3'd0, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h8000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h0000, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h0000, 2'd0, 16'h0, 1'b1, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'hffff, 2'd0, 16'h0, 1'b1, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'hffff, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_UNUSED, 16'hffff, 2'd3, 16'hffff, 1'b1, 1'b1,
                                        3'd7, 32'hffff_ffff));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h1234, 2'd3, 16'hbeef, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_DETACH, 16'h1234, 2'd0, 16'h0, 1'b1, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h1235, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd4, 32'h1));
    pending_requests.push_back(make_req(OP_ATTACH, 16'h7fff, 2'd2, 16'h5555, 1'b0, 1'b0,
                                        3'd1, 32'h0));
    pending_requests.push_back(make_req(OP_ACCESS, 16'h7fff, 2'd0, 16'h0, 1'b0, 1'b0,
                                        3'd4, 32'h0));
    wait_for_drain();

    // Random phases over several limits and idle patterns.
    run_phase(7'd0,   0,  0,  20);
    run_phase(7'd127, 0,  0,  300);
    run_phase(7'd64,  86, 0,  250);
    run_phase(7'd5,   0,  86, 150);
    run_phase(7'd100, 14, 14, 250);

    // Back-pressure: the response side holds off while requests keep coming.
    set_entry_limit(7'd64);
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (150) pending_requests.push_back(random_request());
    @(negedge clk);
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    wait_for_drain();

    run_phase(7'd33, 14, 14, 300);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d responses never arrived", expected_results.size());
    end

    $display("Sent %0d requests and checked %0d responses; table peaked at %0d entries.",
             requests_accepted, results_checked, peak_entries);
    $display("Statuses ok/space/exists/perm/missing/no handler: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Run did not complete in time");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
